// ----- src/gvp_pkg.sv -----
// Shared types, constants and helper functions for the grouped vote packer.
package gvp_pkg;

    localparam int NUM_BINS    = 10;
    localparam int COUNT_WIDTH = 32;
    localparam int BIN_W       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int PROD_W      = COUNT_WIDTH + 8;

    localparam logic [7:0] DOM_NUM_RST = 8'd9;
    localparam logic [7:0] DOM_DEN_RST = 8'd10;

    localparam logic       REG_DOM_NUM = 1'b0;
    localparam logic       REG_DOM_DEN = 1'b1;

    localparam logic       KIND_VOTE  = 1'b0;
    localparam logic       KIND_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        RES_CLOSE = 2'd0,
        RES_OPEN  = 2'd1,
        RES_VOTE  = 2'd2
    } res_kind_t;

    typedef logic [COUNT_WIDTH-1:0]               count_t;
    typedef logic [NUM_BINS-1:0][COUNT_WIDTH-1:0] hist_t;

    typedef struct packed {
        res_kind_t   kind;
        logic [31:0] user;
        logic [31:0] item;
        logic [3:0]  vote;
        logic [31:0] offset;
        logic        disabled;
        logic [31:0] total;
        logic        last;
    } result_t;

    function automatic count_t sat_inc(input count_t v);
        return (v == '1) ? v : count_t'(v + 1'b1);
    endfunction

    function automatic logic [31:0] clamp32(input count_t v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

endpackage

// ----- src/gvp_dominance.sv -----
// Dominance test: any bin scaled by den above the user total scaled by num.
module gvp_dominance (
    input  gvp_pkg::hist_t  hist,
    input  gvp_pkg::count_t user_sum,
    input  logic [7:0]      dom_num,
    input  logic [7:0]      dom_den,
    output logic            dominated
);

    logic [gvp_pkg::PROD_W-1:0]   rhs;
    logic [gvp_pkg::NUM_BINS-1:0] hit;

    assign rhs = gvp_pkg::PROD_W'(dom_num) * gvp_pkg::PROD_W'(user_sum);

    always_comb
    begin
        for (int i = 0; i < gvp_pkg::NUM_BINS; i++)
        begin
            hit[i] = (gvp_pkg::PROD_W'(dom_den) * gvp_pkg::PROD_W'(hist[i])) > rhs;
        end
    end

    assign dominated = |hit;

endmodule

// ----- src/grouped_vote_packer_dominance_flag.sv -----
// Top level: grouped vote packer with per-user dominance flag and APB registers.
// The first result of an item is valid in the cycle after its input beat is accepted.
// One input beat is taken per cycle while each item gives at most one result and out_ready
// is high; an item giving more than one result holds off the input while its results drain
// from the three-deep result queue, until only its last result is left and being taken.
// Reset clears all counters, histogram and queue; dominance_num/den reset to 9/10.
module grouped_vote_packer_dominance_flag (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic signed [31:0] user_id,
    input  logic signed [31:0] item_id,
    input  logic signed [15:0] vote_value,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         result_kind,
    output logic signed [31:0] out_user,
    output logic signed [31:0] out_item,
    output logic [3:0]         out_vote,
    output logic [31:0]        entry_offset,
    output logic               user_disabled,
    output logic [31:0]        user_total,
    output logic               last
);

    logic [7:0]              dom_num_reg;
    logic [7:0]              dom_den_reg;

    logic [31:0]             prev_user_reg,  prev_user_next;
    gvp_pkg::hist_t          hist_reg,       hist_next;
    gvp_pkg::count_t         user_sum_reg,   user_sum_next;
    gvp_pkg::count_t         entry_cnt_reg,  entry_cnt_next;
    gvp_pkg::count_t         user_cnt_reg,   user_cnt_next;

    gvp_pkg::result_t        slot_reg [3];
    gvp_pkg::result_t        slot_next [3];
    logic [1:0]              cnt_reg,        cnt_next;

    logic                    dominated;
    logic                    accept;
    logic                    drain;
    logic                    is_flush;
    logic                    vote_ok;
    logic                    user_chg;
    logic                    do_close;
    logic                    close_any;
    logic [15:0]             vote_raw;
    logic [gvp_pkg::BIN_W-1:0] bin_idx;
    gvp_pkg::count_t         entry_one;
    gvp_pkg::count_t         entry_two;
    gvp_pkg::result_t        close_res;
    gvp_pkg::result_t        open_res;
    gvp_pkg::result_t        vote_res;
    logic [1:0]              n_res;

    gvp_dominance u_dominance (
        .hist      (hist_reg),
        .user_sum  (user_sum_reg),
        .dom_num   (dom_num_reg),
        .dom_den   (dom_den_reg),
        .dominated (dominated)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == gvp_pkg::REG_DOM_DEN) ? 32'(dom_den_reg) : 32'(dom_num_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dom_num_reg <= gvp_pkg::DOM_NUM_RST;
            dom_den_reg <= gvp_pkg::DOM_DEN_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == gvp_pkg::REG_DOM_NUM)
            begin
                dom_num_reg <= pwdata[7:0];
            end
            else
            begin
                dom_den_reg <= pwdata[7:0];
            end
        end
    end

    // handshake
    assign out_valid = (cnt_reg != 2'd0);
    assign drain     = out_valid && out_ready;
    assign in_ready  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign accept    = in_valid && in_ready;

    // decode the beat
    assign vote_raw  = vote_value;
    assign is_flush  = (kind == gvp_pkg::KIND_FLUSH);
    assign vote_ok   = !vote_raw[15] && (vote_raw != 16'd0)
                       && (vote_raw <= 16'(gvp_pkg::NUM_BINS));
    assign user_chg  = (user_id != prev_user_reg);
    assign do_close  = !is_flush && vote_ok && user_chg && (prev_user_reg != 32'd0);
    assign close_any = is_flush || do_close;
    assign bin_idx   = gvp_pkg::BIN_W'(vote_raw - 16'd1);
    assign entry_one = close_any ? gvp_pkg::sat_inc(entry_cnt_reg) : entry_cnt_reg;
    assign entry_two = gvp_pkg::sat_inc(entry_one);

    always_comb
    begin
        close_res          = '0;
        close_res.kind     = gvp_pkg::RES_CLOSE;
        close_res.offset   = gvp_pkg::clamp32(entry_one);
        close_res.disabled = dominated;
        close_res.total    = is_flush ? gvp_pkg::clamp32(user_cnt_reg) : 32'd0;
        close_res.last     = is_flush;

        open_res           = '0;
        open_res.kind      = gvp_pkg::RES_OPEN;
        open_res.user      = user_id;

        vote_res           = '0;
        vote_res.kind      = gvp_pkg::RES_VOTE;
        vote_res.item      = item_id;
        vote_res.vote      = vote_raw[3:0];
        vote_res.last      = 1'b1;

        if (is_flush)
        begin
            n_res = 2'd1;
        end
        else if (!vote_ok)
        begin
            n_res = 2'd0;
        end
        else
        begin
            n_res = 2'd1 + 2'(user_chg) + 2'(do_close);
        end
    end

    // state update
    always_comb
    begin
        prev_user_next = prev_user_reg;
        hist_next      = hist_reg;
        user_sum_next  = user_sum_reg;
        entry_cnt_next = entry_cnt_reg;
        user_cnt_next  = user_cnt_reg;

        if (accept)
        begin
            if (is_flush)
            begin
                prev_user_next = 32'd0;
                hist_next      = '0;
                user_sum_next  = '0;
                entry_cnt_next = '0;
                user_cnt_next  = '0;
            end
            else if (vote_ok)
            begin
                prev_user_next = user_id;
                entry_cnt_next = entry_two;
                user_cnt_next  = user_chg ? gvp_pkg::sat_inc(user_cnt_reg) : user_cnt_reg;
                user_sum_next  = gvp_pkg::sat_inc(do_close ? '0 : user_sum_reg);
                for (int i = 0; i < gvp_pkg::NUM_BINS; i++)
                begin
                    hist_next[i] = do_close ? '0 : hist_reg[i];
                    if (bin_idx == gvp_pkg::BIN_W'(i))
                    begin
                        hist_next[i] = gvp_pkg::sat_inc(hist_next[i]);
                    end
                end
            end
        end
    end

    // result queue: fill on accept, shift on drain
    always_comb
    begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        slot_next[2] = slot_reg[2];
        cnt_next     = cnt_reg;

        if (accept)
        begin
            if (close_any)
            begin
                slot_next[0] = close_res;
            end
            else if (user_chg)
            begin
                slot_next[0] = open_res;
            end
            else
            begin
                slot_next[0] = vote_res;
            end
            slot_next[1] = do_close ? open_res : vote_res;
            slot_next[2] = vote_res;
            cnt_next     = n_res;
        end
        else if (drain)
        begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            cnt_next     = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_user_reg <= '0;
            hist_reg      <= '0;
            user_sum_reg  <= '0;
            entry_cnt_reg <= '0;
            user_cnt_reg  <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            prev_user_reg <= prev_user_next;
            hist_reg      <= hist_next;
            user_sum_reg  <= user_sum_next;
            entry_cnt_reg <= entry_cnt_next;
            user_cnt_reg  <= user_cnt_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
        slot_reg[2] <= slot_next[2];
    end

    // output beat
    assign result_kind   = slot_reg[0].kind;
    assign out_user      = slot_reg[0].user;
    assign out_item      = slot_reg[0].item;
    assign out_vote      = slot_reg[0].vote;
    assign entry_offset  = slot_reg[0].offset;
    assign user_disabled = slot_reg[0].disabled;
    assign user_total    = slot_reg[0].total;
    assign last          = slot_reg[0].last;

endmodule

// ----- tb/sv/grouped_vote_packer_dominance_flag_test.sv -----
// Self-checking testbench for the grouped vote packer: random beats, APB setup, scoreboard.
module grouped_vote_packer_dominance_flag_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic               kind;
        logic [31:0]        user;
        logic [31:0]        item;
        logic signed [15:0] vote;
    } vote_rec_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               kind = gvp_pkg::KIND_VOTE;
    logic signed [31:0] user_id = '0;
    logic signed [31:0] item_id = '0;
    logic signed [15:0] vote_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         result_kind;
    logic signed [31:0] out_user;
    logic signed [31:0] out_item;
    logic [3:0]         out_vote;
    logic [31:0]        entry_offset;
    logic               user_disabled;
    logic [31:0]        user_total;
    logic               last;

    vote_rec_t         vote_feed[$];
    gvp_pkg::result_t  expected_results[$];
    vote_rec_t         cur_rec;
    int          errors = 0;
    int          counted = 0;
    int          accepted = 0;
    int          seen = 0;
    int          hold_left = 0;
    bit          held = 0;

    logic [7:0]  dom_num = gvp_pkg::DOM_NUM_RST;
    logic [7:0]  dom_den = gvp_pkg::DOM_DEN_RST;
    logic [31:0] last_user = '0;
    logic [31:0] hist[gvp_pkg::NUM_BINS];
    logic [31:0] user_votes = '0;
    logic [31:0] entries = '0;
    logic [31:0] users = '0;

    grouped_vote_packer_dominance_flag dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .user_id(user_id),
        .item_id(item_id), .vote_value(vote_value),
        .out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
        .out_user(out_user), .out_item(out_item), .out_vote(out_vote),
        .entry_offset(entry_offset), .user_disabled(user_disabled),
        .user_total(user_total), .last(last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    task automatic close_run(input logic [31:0] tot, input logic fin);
        logic [63:0]      rhs;
        gvp_pkg::result_t r;
        entries = bump(entries);
        rhs = 64'(dom_num) * 64'(user_votes);
        r = '0;
        r.kind = gvp_pkg::RES_CLOSE;
        r.offset = entries;
        r.total = tot;
        r.last = fin;
        for (int b = 0; b < gvp_pkg::NUM_BINS; b++)
        begin
            if (64'(dom_den) * 64'(hist[b]) > rhs)
                r.disabled = 1'b1;
            hist[b] = '0;
        end
        user_votes = '0;
        expected_results.push_back(r);
    endtask

    task automatic pack_votes(input vote_rec_t v);
        gvp_pkg::result_t r;
        if (v.kind == gvp_pkg::KIND_FLUSH)
        begin
            close_run(users, 1'b1);
            last_user = '0;
            entries = '0;
            users = '0;
        end
        else if (v.vote >= 1 && v.vote <= gvp_pkg::NUM_BINS)
        begin
            if (v.user != last_user)
            begin
                users = bump(users);
                if (last_user != 0)
                    close_run('0, 1'b0);
                r = '0;
                r.kind = gvp_pkg::RES_OPEN;
                r.user = v.user;
                expected_results.push_back(r);
                last_user = v.user;
            end
            r = '0;
            r.kind = gvp_pkg::RES_VOTE;
            r.item = v.item;
            r.vote = v.vote[3:0];
            r.last = 1'b1;
            expected_results.push_back(r);
            entries = bump(entries);
            hist[v.vote - 1] = bump(hist[v.vote - 1]);
            user_votes = bump(user_votes);
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                pack_votes(cur_rec);
                accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (vote_feed.size() != 0 &&
                    ((accepted >= 200 && accepted < 280) || $urandom_range(0, 99) >= 16))
                begin
                    cur_rec = vote_feed.pop_front();
                    in_valid <= 1'b1;
                    kind <= cur_rec.kind;
                    user_id <= cur_rec.user;
                    item_id <= cur_rec.item;
                    vote_value <= cur_rec.vote;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        gvp_pkg::result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                seen++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected beat: expected none, actual kind %0d item %h",
                             $time, result_kind, out_item);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("result_kind", 32'(want.kind), 32'(result_kind));
                    check_field("out_user", want.user, out_user);
                    check_field("out_item", want.item, out_item);
                    check_field("out_vote", 32'(want.vote), 32'(out_vote));
                    check_field("entry_offset", want.offset, entry_offset);
                    check_field("user_disabled", 32'(want.disabled), 32'(user_disabled));
                    check_field("user_total", want.total, user_total);
                    check_field("last", 32'(want.last), 32'(last));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!held && seen == 60)
            begin
                held = 1;
                hold_left = 120;
                out_ready <= 1'b0;
            end
            else
                out_ready <= (seen >= 300 && seen < 400) || $urandom_range(0, 99) >= 16;
        end
    end

    task automatic add_rec(input logic k, input logic [31:0] u, input logic [31:0] it,
                           input logic [15:0] vv);
        vote_rec_t r;
        r.kind = k;
        r.user = u;
        r.item = it;
        r.vote = vv;
        vote_feed.push_back(r);
    endtask

    function automatic logic [31:0] pick_user();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return '0;
        else if (sel < 4)
            return 32'($urandom_range(1, 20));
        else
            return $urandom;
    endfunction

    function automatic logic [15:0] bad_vote();
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'($urandom_range(gvp_pkg::NUM_BINS + 1, 32767));
            2: return {1'b1, 15'($urandom)};
            default: return 16'(gvp_pkg::NUM_BINS + 1);
        endcase
    endfunction

    task automatic add_run();
        logic [31:0] u;
        int          n;
        int          fav;
        bit          bias;
        int          v;
        u = pick_user();
        n = $urandom_range(1, 6);
        fav = $urandom_range(1, gvp_pkg::NUM_BINS);
        bias = 1'($urandom_range(0, 1));
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
                add_rec(gvp_pkg::KIND_VOTE, pick_user(), $urandom, bad_vote());
            v = (bias && $urandom_range(0, 3) != 0) ? fav
                                                    : $urandom_range(1, gvp_pkg::NUM_BINS);
            add_rec(gvp_pkg::KIND_VOTE, u, $urandom, 16'(v));
            counted++;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            add_rec(gvp_pkg::KIND_FLUSH, $urandom, $urandom, 16'($urandom));
            counted++;
        end
    endtask

    task automatic drain();
        while (vote_feed.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == gvp_pkg::REG_DOM_NUM)
            dom_num = val;
        else
            dom_den = val;
    endtask

    task automatic random_phase(input logic [7:0] num, input logic [7:0] den);
        write_reg(gvp_pkg::REG_DOM_NUM, num);
        write_reg(gvp_pkg::REG_DOM_DEN, den);
        counted = 0;
        while (counted < 70)
            add_run();
        drain();
    endtask

    initial
    begin
        foreach (hist[b])
            hist[b] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_rec(gvp_pkg::KIND_FLUSH, '0, '0, '0);
        add_rec(gvp_pkg::KIND_VOTE, '0, 32'd1, 16'd1);
        add_rec(gvp_pkg::KIND_VOTE, 32'd3, 32'd2, 16'd0);
        add_rec(gvp_pkg::KIND_VOTE, 32'd3, 32'd2, 16'hFFFF);
        add_rec(gvp_pkg::KIND_VOTE, 32'd3, 32'd2, 16'(gvp_pkg::NUM_BINS + 1));
        add_rec(gvp_pkg::KIND_VOTE, 32'd3, 32'd2, 16'h8000);
        add_rec(gvp_pkg::KIND_VOTE, 32'd3, 32'd2, 16'h7FFF);
        add_rec(gvp_pkg::KIND_VOTE, 32'h7FFF_FFFF, 32'h8000_0000, 16'(gvp_pkg::NUM_BINS));
        add_rec(gvp_pkg::KIND_VOTE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd5);
        add_rec(gvp_pkg::KIND_VOTE, 32'h8000_0000, '0, 16'(gvp_pkg::NUM_BINS));
        repeat (3)
            add_rec(gvp_pkg::KIND_VOTE, 32'h8000_0000, 32'hFFFF_FFFF,
                    16'(gvp_pkg::NUM_BINS));
        add_rec(gvp_pkg::KIND_VOTE, '0, 32'd7, 16'd3);
        add_rec(gvp_pkg::KIND_VOTE, 32'd5, 32'd8, 16'd2);
        add_rec(gvp_pkg::KIND_VOTE, 32'd5, 32'd9, 16'd7);
        add_rec(gvp_pkg::KIND_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_rec(gvp_pkg::KIND_FLUSH, '0, '0, '0);
        add_rec(gvp_pkg::KIND_VOTE, 32'd1, 32'd4, 16'd1);
        add_rec(gvp_pkg::KIND_FLUSH, '0, '0, '0);
        drain();

        random_phase(8'd0, 8'd255);
        random_phase(8'd255, 8'd1);
        random_phase(8'd3, 8'd0);
        random_phase(8'd1, 8'd2);
        random_phase(gvp_pkg::DOM_NUM_RST, gvp_pkg::DOM_DEN_RST);

        repeat (10) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- grouped_vote_packer_dominance_flag.f -----
src/gvp_pkg.sv
src/gvp_dominance.sv
src/grouped_vote_packer_dominance_flag.sv
tb/sv/grouped_vote_packer_dominance_flag_test.sv
